### src/sc2a_pkg.sv
// Shared types, key codes and character tables for the set-1 scancode translator.
// No dependencies; imported by sc2a_decode, scancode_to_ascii_translator and its testbench.
package sc2a_pkg;

    // Key numbers within the 7-bit key field
    localparam logic [6:0] KEY_CTRL   = 7'd29;
    localparam logic [6:0] KEY_LSHIFT = 7'd42;
    localparam logic [6:0] KEY_RSHIFT = 7'd54;
    localparam logic [6:0] KEY_CAPS   = 7'd58;
    localparam logic [6:0] KEY_F1     = 7'd59;
    localparam logic [6:0] KEY_F4     = 7'd62;
    localparam logic [6:0] TABLE_LEN  = 7'd89;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // Result kinds
    localparam logic EVT_CHAR    = 1'b0;
    localparam logic EVT_CONSOLE = 1'b1;

    // Modifier flags
    typedef struct packed {
        logic shift_held;
        logic caps_locked;
        logic ctrl_held;
    } flags_t;

    // One decoded result
    typedef struct packed {
        logic       has_result;
        logic       event_kind;
        logic [7:0] char_code;
        logic [1:0] console_index;
    } result_t;

    // Unshifted character table
    function automatic logic [7:0] plain_map(input logic [6:0] idx);
        logic [7:0] ch;
        case (idx)
            7'd2:  ch = 8'h31;
            7'd3:  ch = 8'h32;
            7'd4:  ch = 8'h33;
            7'd5:  ch = 8'h34;
            7'd6:  ch = 8'h35;
            7'd7:  ch = 8'h36;
            7'd8:  ch = 8'h37;
            7'd9:  ch = 8'h38;
            7'd10: ch = 8'h39;
            7'd11: ch = 8'h30;
            7'd12: ch = 8'h2D;
            7'd13: ch = 8'h3D;
            7'd14: ch = 8'h08;
            7'd16: ch = 8'h71;
            7'd17: ch = 8'h77;
            7'd18: ch = 8'h65;
            7'd19: ch = 8'h72;
            7'd20: ch = 8'h74;
            7'd21: ch = 8'h79;
            7'd22: ch = 8'h75;
            7'd23: ch = 8'h69;
            7'd24: ch = 8'h6F;
            7'd25: ch = 8'h70;
            7'd26: ch = 8'h5B;
            7'd27: ch = 8'h5D;
            7'd28: ch = 8'h0D;
            7'd30: ch = 8'h61;
            7'd31: ch = 8'h73;
            7'd32: ch = 8'h64;
            7'd33: ch = 8'h66;
            7'd34: ch = 8'h67;
            7'd35: ch = 8'h68;
            7'd36: ch = 8'h6A;
            7'd37: ch = 8'h6B;
            7'd38: ch = 8'h6C;
            7'd39: ch = 8'h3B;
            7'd40: ch = 8'h27;
            7'd41: ch = 8'h60;
            7'd43: ch = 8'h23;
            7'd44: ch = 8'h7A;
            7'd45: ch = 8'h78;
            7'd46: ch = 8'h63;
            7'd47: ch = 8'h76;
            7'd48: ch = 8'h62;
            7'd49: ch = 8'h6E;
            7'd50: ch = 8'h6D;
            7'd51: ch = 8'h2C;
            7'd52: ch = 8'h2E;
            7'd53: ch = 8'h2F;
            7'd57: ch = 8'h20;
            7'd72: ch = 8'd21;
            7'd75: ch = 8'd12;
            7'd77: ch = 8'd18;
            7'd80: ch = 8'd4;
            7'd83: ch = 8'd127;
            7'd86: ch = 8'h5C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Shifted character table
    function automatic logic [7:0] shift_map(input logic [6:0] idx);
        logic [7:0] ch;
        case (idx)
            7'd2:  ch = 8'h21;
            7'd3:  ch = 8'h22;
            7'd4:  ch = 8'h23;
            7'd5:  ch = 8'h24;
            7'd6:  ch = 8'h25;
            7'd7:  ch = 8'h5E;
            7'd8:  ch = 8'h26;
            7'd9:  ch = 8'h2A;
            7'd10: ch = 8'h28;
            7'd11: ch = 8'h29;
            7'd12: ch = 8'h5F;
            7'd13: ch = 8'h2B;
            7'd14: ch = 8'h08;
            7'd16: ch = 8'h51;
            7'd17: ch = 8'h57;
            7'd18: ch = 8'h45;
            7'd19: ch = 8'h52;
            7'd20: ch = 8'h54;
            7'd21: ch = 8'h59;
            7'd22: ch = 8'h55;
            7'd23: ch = 8'h49;
            7'd24: ch = 8'h4F;
            7'd25: ch = 8'h50;
            7'd26: ch = 8'h7B;
            7'd27: ch = 8'h7D;
            7'd28: ch = 8'h0D;
            7'd30: ch = 8'h41;
            7'd31: ch = 8'h53;
            7'd32: ch = 8'h44;
            7'd33: ch = 8'h46;
            7'd34: ch = 8'h47;
            7'd35: ch = 8'h48;
            7'd36: ch = 8'h4A;
            7'd37: ch = 8'h4B;
            7'd38: ch = 8'h4C;
            7'd39: ch = 8'h3A;
            7'd40: ch = 8'h40;
            7'd41: ch = 8'h60;
            7'd43: ch = 8'h23;
            7'd44: ch = 8'h5A;
            7'd45: ch = 8'h58;
            7'd46: ch = 8'h43;
            7'd47: ch = 8'h56;
            7'd48: ch = 8'h42;
            7'd49: ch = 8'h4E;
            7'd50: ch = 8'h4D;
            7'd51: ch = 8'h3C;
            7'd52: ch = 8'h3E;
            7'd53: ch = 8'h3F;
            7'd57: ch = 8'h20;
            7'd74: ch = 8'h2D;
            7'd76: ch = 8'h35;
            7'd78: ch = 8'h2B;
            7'd83: ch = 8'd127;
            7'd86: ch = 8'h7C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Ctrl table: control codes on letter keys, shifted table elsewhere
    function automatic logic [7:0] ctrl_map(input logic [6:0] idx);
        logic [7:0] ch;
        case (idx)
            7'd16: ch = 8'd17;
            7'd17: ch = 8'd23;
            7'd18: ch = 8'd5;
            7'd19: ch = 8'd18;
            7'd20: ch = 8'd20;
            7'd21: ch = 8'd25;
            7'd22: ch = 8'd21;
            7'd23: ch = 8'd9;
            7'd24: ch = 8'd15;
            7'd25: ch = 8'd16;
            7'd30: ch = 8'd1;
            7'd31: ch = 8'd19;
            7'd32: ch = 8'd4;
            7'd33: ch = 8'd6;
            7'd34: ch = 8'd7;
            7'd35: ch = 8'd8;
            7'd36: ch = 8'd10;
            7'd37: ch = 8'd11;
            7'd38: ch = 8'd12;
            7'd44: ch = 8'd26;
            7'd45: ch = 8'd24;
            7'd46: ch = 8'd3;
            7'd47: ch = 8'd22;
            7'd48: ch = 8'd2;
            7'd49: ch = 8'd14;
            7'd50: ch = 8'd13;
            default: ch = shift_map(idx);
        endcase
        return ch;
    endfunction

endpackage

### src/sc2a_decode.sv
// Combinational decode of one scancode: next modifier flags and the result.
// Depends on sc2a_pkg for key codes, tables and the flag/result structs.
module sc2a_decode (
    input  logic [7:0]      scan_code,
    input  sc2a_pkg::flags_t flags,
    output sc2a_pkg::flags_t flags_next,
    output sc2a_pkg::result_t result
);
    import sc2a_pkg::*;

    logic [6:0] key;
    logic [7:0] ch_raw;
    logic [7:0] ch;
    logic [6:0] f_off;

    assign key   = scan_code[6:0];
    assign f_off = key - KEY_F1;

    // Pick the table by modifier precedence, zero past the table end
    always_comb
    begin
        if (key >= TABLE_LEN)
            ch_raw = 8'h00;
        else if (flags.ctrl_held)
            ch_raw = ctrl_map(key);
        else if (flags.shift_held)
            ch_raw = shift_map(key);
        else
            ch_raw = plain_map(key);
    end

    // Swap letter case under caps lock
    always_comb
    begin
        ch = ch_raw;
        if (flags.caps_locked)
        begin
            if (ch_raw inside {[8'h41:8'h5A]})
                ch = ch_raw + CASE_BIT;
            else if (ch_raw inside {[8'h61:8'h7A]})
                ch = ch_raw - CASE_BIT;
        end
    end

    // Update flags and form the result
    always_comb
    begin
        flags_next           = flags;
        result.has_result    = 1'b0;
        result.event_kind    = EVT_CHAR;
        result.char_code     = 8'h00;
        result.console_index = 2'd0;
        if (scan_code[7])
        begin
            if (key == KEY_LSHIFT || key == KEY_RSHIFT)
                flags_next.shift_held = 1'b0;
            else if (key == KEY_CTRL)
                flags_next.ctrl_held = 1'b0;
        end
        else if (key == KEY_LSHIFT || key == KEY_RSHIFT)
            flags_next.shift_held = 1'b1;
        else if (key == KEY_CTRL)
            flags_next.ctrl_held = 1'b1;
        else if (key == KEY_CAPS)
            flags_next.caps_locked = !flags.caps_locked;
        else if (key inside {[KEY_F1:KEY_F4]})
        begin
            result.has_result    = 1'b1;
            result.event_kind    = EVT_CONSOLE;
            result.console_index = f_off[1:0];
        end
        else
        begin
            result.has_result = 1'b1;
            result.char_code  = ch;
        end
    end

endmodule

### src/scancode_to_ascii_translator.sv
// Set-1 scancode to character translator, top level.
// A scancode is held in the input register, decoded, then held in the result register.
// Throughput: one scancode per cycle while the result register is free, set by the
// single decode stage between the registers; modifier and caps codes give no result.
// Reset: rst_n clears the shift, caps lock and ctrl flags and empties both stages.
// Depends on sc2a_pkg and sc2a_decode.
module scancode_to_ascii_translator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] scan_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       event_kind,
    output logic [7:0] char_code,
    output logic [1:0] console_index
);
    import sc2a_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_code_reg;
    flags_t     flags_reg;
    flags_t     flags_next;
    result_t    dec_result;
    logic       out_valid_reg;
    logic       out_kind_reg;
    logic [7:0] out_char_reg;
    logic [1:0] out_con_reg;
    logic       out_free;
    logic       s1_advance;

    sc2a_decode u_decode (
        .scan_code  (s1_code_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .result     (dec_result)
    );

    // Advance the input stage when its result has room or it makes none
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && (!dec_result.has_result || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_code_reg <= scan_code;
    end

    // Commit modifier flags as each transaction leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else if (s1_advance)
            flags_reg <= flags_next;
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_advance && dec_result.has_result;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (out_free && s1_advance && dec_result.has_result)
        begin
            out_kind_reg <= dec_result.event_kind;
            out_char_reg <= dec_result.char_code;
            out_con_reg  <= dec_result.console_index;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = out_kind_reg;
    assign char_code     = out_char_reg;
    assign console_index = out_con_reg;

`ifndef SYNTH
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stage empty but not ready");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_code_reg))
        else $error("stalled input stage lost its scancode");

    a_console_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EVT_CONSOLE |-> char_code == 8'h00)
        else $error("console switch result carries a character");

    a_char_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EVT_CHAR |-> console_index == 2'd0)
        else $error("character result carries a console index");

    a_caps_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(flags_reg.caps_locked) |->
            $past(s1_advance && s1_code_reg == {1'b0, KEY_CAPS}))
        else $error("caps lock changed without a caps press");
`endif

endmodule

### tb/scancode_to_ascii_translator_tb.sv
// Testbench for scancode_to_ascii_translator: drives set-1 scancodes, predicts the
// characters and console switches they cause, and checks every result in order.
// Depends on sc2a_pkg (key codes, result kinds) and the translator RTL.
`timescale 1ns / 100ps

module scancode_to_ascii_translator_tb;
    import sc2a_pkg::*;

    localparam int         STALL_LIMIT  = 2000;
    localparam int         HOLD_CYCLES  = 150;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

    // One pending scancode, or a marker that makes the sender wait for all results
    typedef struct packed {
        logic       pause;
        logic [7:0] code;
    } scan_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] code_char;
        logic [1:0] console;
    } key_event_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] scan_code = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       event_kind;
    logic [7:0] char_code;
    logic [1:0] console_index;

    scan_item_t scan_queue[$];
    key_event_t pending_events[$];

    // Modifier flags as the keyboard sees them
    logic shift_on = 1'b0;
    logic caps_on = 1'b0;
    logic ctrl_on = 1'b0;

    int   errors = 0;
    int   keys_sent = 0;
    int   results_seen = 0;
    int   chars_checked = 0;
    int   switches_checked = 0;
    int   caps_chars = 0;
    int   idle_cycles = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    logic tx_no_idle = 1'b0;
    logic rx_no_idle = 1'b0;
    logic hold_rx = 1'b0;

    // Key-number indexed character tables
    logic [7:0] plain_chars [0:88] = '{
        0, 0, 49, 50, 51, 52, 53, 54, 55, 56, 57, 48, 45, 61, 8, 0,
        113, 119, 101, 114, 116, 121, 117, 105, 111, 112, 91, 93, 13, 0,
        97, 115, 100, 102, 103, 104, 106, 107, 108, 59, 39, 96, 0, 35,
        122, 120, 99, 118, 98, 110, 109, 44, 46, 47, 0, 0, 0, 32, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        21, 0, 0, 12, 0, 18, 0, 0, 4, 0, 0, 127, 0, 0, 92, 0, 0
    };

    logic [7:0] shifted_chars [0:88] = '{
        0, 0, 33, 34, 35, 36, 37, 94, 38, 42, 40, 41, 95, 43, 8, 0,
        81, 87, 69, 82, 84, 89, 85, 73, 79, 80, 123, 125, 13, 0,
        65, 83, 68, 70, 71, 72, 74, 75, 76, 58, 64, 96, 0, 35,
        90, 88, 67, 86, 66, 78, 77, 60, 62, 63, 0, 0, 0, 32, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 45, 0, 53, 0, 43, 0, 0, 0, 0, 127, 0, 0, 124, 0, 0
    };

    logic [7:0] control_chars [0:88] = '{
        0, 0, 33, 34, 35, 36, 37, 94, 38, 42, 40, 41, 95, 43, 8, 0,
        17, 23, 5, 18, 20, 25, 21, 9, 15, 16, 123, 125, 13, 0,
        1, 19, 4, 6, 7, 8, 10, 11, 12, 58, 64, 96, 0, 35,
        26, 24, 3, 22, 2, 14, 13, 60, 62, 63, 0, 0, 0, 32, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 45, 0, 53, 0, 43, 0, 0, 0, 0, 127, 0, 0, 124, 0, 0
    };

    scancode_to_ascii_translator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .scan_code     (scan_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .char_code     (char_code),
        .console_index (console_index)
    );

    always #5 clk = ~clk;

    // Update the modifier flags for one scancode; return 1 when it yields an event
    function automatic bit translate_key(input logic [7:0] code, output key_event_t ev);
        logic [6:0] key;
        logic [7:0] ch;
        key = code[6:0];
        ev  = '0;
        if (code[7]) begin
            if (key == KEY_LSHIFT || key == KEY_RSHIFT)
                shift_on = 1'b0;
            else if (key == KEY_CTRL)
                ctrl_on = 1'b0;
            return 1'b0;
        end
        if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
            shift_on = 1'b1;
            return 1'b0;
        end
        if (key == KEY_CTRL) begin
            ctrl_on = 1'b1;
            return 1'b0;
        end
        if (key == KEY_CAPS) begin
            caps_on = ~caps_on;
            return 1'b0;
        end
        if (key >= KEY_F1 && key <= KEY_F4) begin
            ev.kind    = EVT_CONSOLE;
            ev.console = 2'(key - KEY_F1);
            return 1'b1;
        end
        // Pick the table by precedence; keys past the tables read zero
        if (key >= TABLE_LEN)
            ch = 8'h00;
        else if (ctrl_on)
            ch = control_chars[key];
        else if (shift_on)
            ch = shifted_chars[key];
        else
            ch = plain_chars[key];
        if (caps_on) begin
            if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z)
                ch = ch + CASE_BIT;
            else if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z)
                ch = ch - CASE_BIT;
        end
        ev.kind      = EVT_CHAR;
        ev.code_char = ch;
        return 1'b1;
    endfunction

    task automatic queue_key(input logic [7:0] code);
        scan_queue.push_back('{pause: 1'b0, code: code});
    endtask

    task automatic queue_pause();
        scan_queue.push_back('{pause: 1'b1, code: 8'h00});
    endtask

    // Sender: present queued scancodes, predict each accepted transaction
    always @(posedge clk) begin : sender
        logic       took;
        key_event_t ev;
        scan_item_t item;
        took = in_valid && in_ready;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            scan_code <= 8'h00;
        end
        else if (!(in_valid && !took)) begin
            if (took) begin
                if (translate_key(scan_code, ev)) begin
                    pending_events.push_back(ev);
                    if (ev.kind == EVT_CHAR && caps_on)
                        caps_chars++;
                end
                keys_sent++;
                if (keys_sent % 128 == 0)
                    tx_no_idle = ($urandom_range(0, 3) == 0);
                send_gap = (tx_no_idle || hold_rx) ? 0 : $urandom_range(0, 7);
            end
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (scan_queue.size() != 0 && scan_queue[0].pause) begin
                // Hold off until every predicted event has come out
                in_valid <= 1'b0;
                if (pending_events.size() == 0)
                    void'(scan_queue.pop_front());
            end
            else if (scan_queue.size() != 0) begin
                item = scan_queue.pop_front();
                in_valid  <= 1'b1;
                scan_code <= item.code;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, compare each result transaction with the oldest prediction
    always @(posedge clk) begin : receiver
        key_event_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (pending_events.size() == 0) begin
                    $display("%0t: unexpected result, kind %0d char %0d console %0d",
                             $time, event_kind, char_code, console_index);
                    errors++;
                end
                else begin
                    want = pending_events.pop_front();
                    if (event_kind !== want.kind) begin
                        $display("%0t: event_kind mismatch, expected %0d, got %0d",
                                 $time, want.kind, event_kind);
                        errors++;
                    end
                    if (char_code !== want.code_char) begin
                        $display("%0t: char_code mismatch, expected %0d, got %0d",
                                 $time, want.code_char, char_code);
                        errors++;
                    end
                    if (console_index !== want.console) begin
                        $display("%0t: console_index mismatch, expected %0d, got %0d",
                                 $time, want.console, console_index);
                        errors++;
                    end
                    if (want.kind == EVT_CONSOLE)
                        switches_checked++;
                    else
                        chars_checked++;
                end
                if (results_seen % 128 == 0)
                    rx_no_idle = ($urandom_range(0, 3) == 0);
                recv_gap = rx_no_idle ? 0 : $urandom_range(0, 7);
            end
            if (hold_rx) begin
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Block the receiver for a long stretch so the input side backs up
    initial begin : long_hold
        wait (keys_sent >= 600);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Abort when no transaction moves for too long
    always @(posedge clk) begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d events outstanding",
                     $time, STALL_LIMIT, pending_events.size());
            $display("** scancode_to_ascii_translator: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int         pick;
        logic [6:0] key;

        // Directed: code extremes, table edge, F-keys, modifier and caps combinations
        queue_key(8'h00);
        queue_key(8'h7F);
        queue_key(8'h80);
        queue_key(8'hFF);
        queue_key({1'b0, TABLE_LEN - 7'd1});
        queue_key({1'b0, TABLE_LEN});
        for (int f = 0; f < 4; f++)
            queue_key({1'b0, KEY_F1 + 7'(f)});
        queue_key(8'd30);
        queue_key({1'b0, KEY_LSHIFT});
        queue_key(8'd30);
        queue_key(8'd2);
        queue_key({1'b1, KEY_LSHIFT});
        queue_key({1'b0, KEY_RSHIFT});
        queue_key(8'd74);
        queue_key({1'b1, KEY_RSHIFT});
        queue_key({1'b0, KEY_CAPS});
        queue_key(8'd30);
        queue_key({1'b1, KEY_CAPS});
        queue_key({1'b0, KEY_CTRL});
        queue_key(8'd30);
        queue_key({1'b1, KEY_CTRL});
        queue_key({1'b0, KEY_CAPS});
        queue_pause();

        // Random: mostly typing with modifiers, some raw noise
        for (int i = 0; i < 1625; i++) begin
            pick = $urandom_range(0, 99);
            key  = 7'($urandom_range(0, TABLE_LEN - 1));
            if (i % 400 == 399)
                queue_pause();
            if (pick < 10)
                queue_key(8'($urandom_range(0, 255)));
            else if (pick < 55)
                queue_key({1'b0, key});
            else if (pick < 65)
                queue_key({1'b1, key});
            else if (pick < 77)
                queue_key({1'($urandom_range(0, 1)),
                           $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT});
            else if (pick < 85)
                queue_key({1'($urandom_range(0, 1)), KEY_CTRL});
            else if (pick < 91)
                queue_key({($urandom_range(0, 3) == 0), KEY_CAPS});
            else if (pick < 96)
                queue_key({1'b0, KEY_F1 + 7'($urandom_range(0, 3))});
            else
                queue_key({1'b0, 7'($urandom_range(TABLE_LEN, 127))});
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all scancodes in, all events out, then let the pipeline settle
        while (scan_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d scancodes; checked %0d characters (%0d under caps lock)",
                 keys_sent, chars_checked, caps_chars);
        $display("and %0d console switches, across random stalls and a long receiver hold",
                 switches_checked);
        if (errors == 0)
            $display("** scancode_to_ascii_translator: PASSED **");
        else
            $display("** scancode_to_ascii_translator: FAILED **");
        $finish;
    end

endmodule
